// ----- src/vga_pkg.sv -----
// Shared constants, opcodes, pipeline records and saturation helper for the vector ALU.
`default_nettype none
package vga_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QB        = 41;   // quotient bits kept by the divider
  localparam int SQ_STEPS  = 32;   // root bits of a 64-bit radicand

  localparam logic [3:0] OP_NEG    = 4'd0;
  localparam logic [3:0] OP_ADD    = 4'd1;
  localparam logic [3:0] OP_SUB    = 4'd2;
  localparam logic [3:0] OP_SCALE  = 4'd3;
  localparam logic [3:0] OP_DIV    = 4'd4;
  localparam logic [3:0] OP_LEN    = 4'd5;
  localparam logic [3:0] OP_CCW    = 4'd6;
  localparam logic [3:0] OP_CW     = 4'd7;
  localparam logic [3:0] OP_DOT    = 4'd8;
  localparam logic [3:0] OP_CROSS  = 4'd9;
  localparam logic [3:0] OP_NORM   = 4'd10;
  localparam logic [3:0] OP_PROJ   = 4'd11;
  localparam logic [3:0] OP_ORT    = 4'd12;
  localparam logic [3:0] OP_MBY    = 4'd13;
  localparam logic [3:0] OP_MALONG = 4'd14;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  localparam logic [63:0] HALF_LSB = 64'd1 << (FRAC_BITS - 1);
  localparam logic [QB-1:0] Q_LIMIT = {1'b1, {(QB-1){1'b0}}};

  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [3:0]         op;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] f;
    logic [31:0]        sx;
    logic [31:0]        sy;
    logic [31:0]        ss;
    logic               sclamp;
    logic               d_neg;
    logic [63:0]        d_mag;
    logic [63:0]        bb;
    logic [63:0]        sq;
    logic [32:0]        len;
  } item_t;

  typedef struct packed {
    item_t       it;
    logic [63:0] den;
    logic        dz;
    logic [1:0]  sgn;
    logic [1:0]  ovf;
  } dv_t;

  typedef struct packed {
    logic        clamp;
    logic [31:0] val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t r;
    if (v > SAT_MAX) begin
      r.clamp = 1'b1;
      r.val   = 32'h7fff_ffff;
    end else if (v < SAT_MIN) begin
      r.clamp = 1'b1;
      r.val   = 32'h8000_0000;
    end else begin
      r.clamp = 1'b0;
      r.val   = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/vga_front.sv -----
// Front end: input register, products, sums, rounding and saturation of the simple ops.
`default_nettype none
module vga_front import vga_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_vld,
  input  wire logic [3:0]         opcode,
  input  wire logic signed [31:0] a_x,
  input  wire logic signed [31:0] a_y,
  input  wire logic signed [31:0] b_x,
  input  wire logic signed [31:0] b_y,
  input  wire logic signed [31:0] factor,
  output logic                    out_vld,
  output item_t                   out_item
);

  function automatic logic [63:0] abs65(input logic signed [64:0] v);
    logic signed [64:0] t;
    t = v[64] ? -v : v;
    return t[63:0];
  endfunction

  function automatic logic [63:0] rnd(input logic [63:0] m, input logic nar);
    return nar ? ((m + HALF_LSB) >> FRAC_BITS) : m;
  endfunction

  // F0
  item_t it0, it0_next;
  logic  v0;
  always_comb begin
    it0_next    = '0;
    it0_next.op = opcode;
    it0_next.ax = a_x;
    it0_next.ay = a_y;
    it0_next.bx = b_x;
    it0_next.by = b_y;
    it0_next.f  = factor;
  end
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else v0 <= in_vld;
    it0 <= it0_next;
  end

  // F1: four products, operands picked by opcode
  logic signed [31:0] ma0, mb0, ma1, mb1;
  logic signed [63:0] m0, m1, m2, m3;
  item_t it1;
  logic  v1;
  always_comb begin
    ma0 = it0.ax;
    mb0 = it0.bx;
    ma1 = it0.ay;
    mb1 = it0.by;
    unique case (it0.op) inside
      OP_SCALE: begin
        mb0 = it0.f;
        mb1 = it0.f;
      end
      OP_CROSS: begin
        mb0 = it0.by;
        mb1 = it0.bx;
      end
      OP_LEN, OP_NORM: begin
        mb0 = it0.ax;
        mb1 = it0.ay;
      end
      default: ;
    endcase
  end
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= v0;
    it1 <= it0;
    m0  <= ma0 * mb0;
    m1  <= ma1 * mb1;
    m2  <= it0.bx * it0.bx;
    m3  <= it0.by * it0.by;
  end

  // F2: sums and result pick
  logic signed [64:0] m0x, m1x, ax_e, ay_e, bx_e, by_e, e;
  logic signed [64:0] vx, vy, vs, vx2, vy2, vs2, e2;
  logic  nar_v, nar_s, nar_v2, nar_s2;
  item_t it1_next, it2;
  logic  v2;
  always_comb begin
    m0x  = 65'(m0);
    m1x  = 65'(m1);
    ax_e = 65'(it1.ax);
    ay_e = 65'(it1.ay);
    bx_e = 65'(it1.bx);
    by_e = 65'(it1.by);
    e    = (it1.op == OP_CROSS) ? m0x - m1x : m0x + m1x;
    vx = '0;
    vy = '0;
    vs = '0;
    nar_v = 1'b0;
    nar_s = 1'b0;
    unique case (it1.op) inside
      OP_NEG: begin
        vx = -ax_e;
        vy = -ay_e;
      end
      OP_ADD: begin
        vx = ax_e + bx_e;
        vy = ay_e + by_e;
      end
      OP_SUB: begin
        vx = ax_e - bx_e;
        vy = ay_e - by_e;
      end
      OP_SCALE: begin
        vx = m0x;
        vy = m1x;
        nar_v = 1'b1;
      end
      OP_CCW: begin
        vx = -ay_e;
        vy = ax_e;
      end
      OP_CW: begin
        vx = ay_e;
        vy = -ax_e;
      end
      OP_DOT, OP_CROSS: begin
        vs = e;
        nar_s = 1'b1;
      end
      default: ;
    endcase
    it1_next    = it1;
    it1_next.bb = $unsigned(m2) + $unsigned(m3);
    it1_next.sq = e[63:0];
  end
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    it2    <= it1_next;
    vx2    <= vx;
    vy2    <= vy;
    vs2    <= vs;
    e2     <= e;
    nar_v2 <= nar_v;
    nar_s2 <= nar_s;
  end

  // F3: magnitudes, round to nearest on the magnitude
  item_t it2_next, it3;
  logic  v3, negx, negy, negs;
  logic [63:0] magx, magy, mags;
  always_comb begin
    it2_next       = it2;
    it2_next.d_neg = e2[64];
    it2_next.d_mag = abs65(e2);
  end
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    it3  <= it2_next;
    negx <= vx2[64];
    negy <= vy2[64];
    negs <= vs2[64];
    magx <= rnd(abs65(vx2), nar_v2);
    magy <= rnd(abs65(vy2), nar_v2);
    mags <= rnd(abs65(vs2), nar_s2);
  end

  // F4: sign back on, clamp
  logic signed [63:0] svx, svy, svs;
  sat_t  tx, ty, ts;
  item_t it3_next;
  always_comb begin
    svx = negx ? -$signed(magx) : $signed(magx);
    svy = negy ? -$signed(magy) : $signed(magy);
    svs = negs ? -$signed(mags) : $signed(mags);
    tx  = sat32(svx);
    ty  = sat32(svy);
    ts  = sat32(svs);
    it3_next        = it3;
    it3_next.sx     = tx.val;
    it3_next.sy     = ty.val;
    it3_next.ss     = ts.val;
    it3_next.sclamp = tx.clamp | ty.clamp | ts.clamp;
  end
  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else out_vld <= v3;
    out_item <= it3_next;
  end

endmodule
`default_nettype wire

// ----- src/vga_sqrt.sv -----
// Pipelined square root of the squared length, one root bit per stage, rounded to nearest.
`default_nettype none
module vga_sqrt import vga_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_vld,
  input  wire item_t in_item,
  output logic       out_vld,
  output item_t      out_item
);

  item_t       it_q   [0:SQ_STEPS];
  logic        v_q    [0:SQ_STEPS];
  logic [34:0] rem_q  [0:SQ_STEPS];
  logic [31:0] root_q [0:SQ_STEPS];

  always_ff @(posedge clk) begin
    if (rst) v_q[0] <= 1'b0;
    else v_q[0] <= in_vld;
    it_q[0]   <= in_item;
    rem_q[0]  <= '0;
    root_q[0] <= '0;
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    logic [34:0] rn, tr;
    // remainder never exceeds twice the partial root, so 33 bits carry it
    assign rn = {rem_q[k][32:0], it_q[k].sq[2*(SQ_STEPS-k)-1 -: 2]};
    assign tr = {1'b0, root_q[k], 2'b01};
    always_ff @(posedge clk) begin
      if (rst) v_q[k+1] <= 1'b0;
      else v_q[k+1] <= v_q[k];
      it_q[k+1] <= it_q[k];
      if (rn >= tr) begin
        rem_q[k+1]  <= rn - tr;
        root_q[k+1] <= {root_q[k][30:0], 1'b1};
      end else begin
        rem_q[k+1]  <= rn;
        root_q[k+1] <= {root_q[k][30:0], 1'b0};
      end
    end
  end

  item_t fin;
  always_comb begin
    fin     = it_q[SQ_STEPS];
    fin.len = {1'b0, root_q[SQ_STEPS]}
            + 33'(rem_q[SQ_STEPS] > {3'b0, root_q[SQ_STEPS]});
  end

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else out_vld <= v_q[SQ_STEPS];
    out_item <= fin;
  end

endmodule
`default_nettype wire

// ----- src/vga_div.sv -----
// Operand setup and two-lane restoring divider pipeline, one quotient bit per stage.
`default_nettype none
module vga_div import vga_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_vld,
  input  wire item_t              in_item,
  output logic                    out_vld,
  output dv_t                     out_meta,
  output logic [1:0][63:0]        out_rem,
  output logic [1:0][QB-1:0]      out_quo
);

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // D0: |b.x| and |b.y| times |a.b|, split in 32-bit halves
  logic [31:0] cx, cy;
  logic [63:0] plo [0:1];
  logic [63:0] phi [0:1];
  item_t ita;
  logic  va;
  always_comb begin
    cx = abs32(in_item.bx);
    cy = abs32(in_item.by);
  end
  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else va <= in_vld;
    ita    <= in_item;
    plo[0] <= cx * in_item.d_mag[31:0];
    phi[0] <= cx * in_item.d_mag[63:32];
    plo[1] <= cy * in_item.d_mag[31:0];
    phi[1] <= cy * in_item.d_mag[63:32];
  end

  // D1: pick numerator, divisor, result sign
  logic [95:0] num_next [0:1];
  logic [95:0] num      [0:1];
  logic [31:0] amag     [0:1];
  logic        asgn     [0:1];
  logic        csgn     [0:1];
  logic        is_proj;
  dv_t  mb_next, mb;
  logic vb;
  always_comb begin
    amag[0] = abs32(ita.ax);
    amag[1] = abs32(ita.ay);
    asgn[0] = ita.ax[31];
    asgn[1] = ita.ay[31];
    csgn[0] = ita.bx[31];
    csgn[1] = ita.by[31];
    is_proj = (ita.op == OP_PROJ) || (ita.op == OP_ORT) ||
              (ita.op == OP_MBY) || (ita.op == OP_MALONG);
    mb_next     = '0;
    mb_next.it  = ita;
    mb_next.den = 64'd1;
    for (int l = 0; l < 2; l++) begin
      if (is_proj) num_next[l] = 96'(plo[l]) + {phi[l], 32'b0};
      else num_next[l] = 96'(amag[l]) << FRAC_BITS;
    end
    unique case (ita.op) inside
      OP_DIV: begin
        mb_next.den = 64'(abs32(ita.f));
        mb_next.dz  = (ita.f == '0);
        mb_next.sgn = {asgn[1] ^ ita.f[31], asgn[0] ^ ita.f[31]};
      end
      OP_NORM: begin
        mb_next.den = 64'(ita.len);
        mb_next.dz  = (ita.len == '0);
        mb_next.sgn = {asgn[1], asgn[0]};
      end
      OP_PROJ, OP_ORT, OP_MBY, OP_MALONG: begin
        mb_next.den = ita.bb;
        mb_next.dz  = (ita.bb == '0);
        mb_next.sgn = {csgn[1] ^ ita.d_neg, csgn[0] ^ ita.d_neg};
      end
      default: ;
    endcase
  end
  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else vb <= va;
    mb     <= mb_next;
    num[0] <= num_next[0];
    num[1] <= num_next[1];
  end

  // D2 and iterations
  dv_t           m_q   [0:QB];
  logic          v_q   [0:QB];
  logic [63:0]   rem_q [0:1][0:QB];
  logic [QB-1:0] q_q   [0:1][0:QB];
  logic [QB-1:0] lo_q  [0:1][0:QB];
  dv_t           m0_next;

  // quotient that needs more than QB bits is flagged and clamped later
  always_comb begin
    m0_next = mb;
    for (int l = 0; l < 2; l++)
      m0_next.ovf[l] = 64'(num[l][95:QB]) >= mb.den;
  end

  always_ff @(posedge clk) begin
    if (rst) v_q[0] <= 1'b0;
    else v_q[0] <= vb;
    m_q[0]      <= m0_next;
    rem_q[0][0] <= 64'(num[0][95:QB]);
    rem_q[1][0] <= 64'(num[1][95:QB]);
    lo_q[0][0]  <= num[0][QB-1:0];
    lo_q[1][0]  <= num[1][QB-1:0];
    q_q[0][0]   <= '0;
    q_q[1][0]   <= '0;
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) v_q[k+1] <= 1'b0;
      else v_q[k+1] <= v_q[k];
      m_q[k+1] <= m_q[k];
    end
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [64:0] rn;
      assign rn = {rem_q[l][k], lo_q[l][k][QB-1-k]};
      always_ff @(posedge clk) begin
        lo_q[l][k+1] <= lo_q[l][k];
        if (rn >= {1'b0, m_q[k].den}) begin
          rem_q[l][k+1] <= 64'(rn - {1'b0, m_q[k].den});
          q_q[l][k+1]   <= {q_q[l][k][QB-2:0], 1'b1};
        end else begin
          rem_q[l][k+1] <= rn[63:0];
          q_q[l][k+1]   <= {q_q[l][k][QB-2:0], 1'b0};
        end
      end
    end
  end

  assign out_vld  = v_q[QB];
  assign out_meta = m_q[QB];
  for (genvar l = 0; l < 2; l++) begin : g_out
    assign out_rem[l] = rem_q[l][QB];
    assign out_quo[l] = q_q[l][QB];
  end

endmodule
`default_nettype wire

// ----- src/vga_back.sv -----
// Back end: quotient rounding, projection combine, saturation and result register.
`default_nettype none
module vga_back import vga_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_vld,
  input  wire dv_t                in_meta,
  input  wire logic [1:0][63:0]   in_rem,
  input  wire logic [1:0][QB-1:0] in_quo,
  output logic                    done,
  output logic signed [31:0]      r_x,
  output logic signed [31:0]      r_y,
  output logic signed [31:0]      scalar_out,
  output logic [1:0]              status
);

  // B0: round half up on the remainder, clamp
  logic [1:0]    up;
  logic [QB:0]   qr      [0:1];
  logic [QB-1:0] qm_next [0:1];
  logic [QB-1:0] qm      [0:1];
  dv_t  mq;
  logic vq;
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      up[l] = {in_rem[l], 1'b0} >= {1'b0, in_meta.den};
      qr[l] = {1'b0, in_quo[l]} + {{QB{1'b0}}, up[l]};
      if (in_meta.ovf[l] || qr[l] > {1'b0, Q_LIMIT}) qm_next[l] = Q_LIMIT;
      else qm_next[l] = qr[l][QB-1:0];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) vq <= 1'b0;
    else vq <= in_vld;
    mq    <= in_meta;
    qm[0] <= qm_next[0];
    qm[1] <= qm_next[1];
  end

  // B1: signed quotient p, then p, a - p, 2p - a or a - 2p
  logic signed [QB:0] sp       [0:1];
  logic signed [63:0] pv       [0:1];
  logic signed [63:0] av       [0:1];
  logic signed [63:0] val_next [0:1];
  logic signed [63:0] val      [0:1];
  dv_t  mc;
  logic vc;
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sp[l] = mq.sgn[l] ? -$signed({1'b0, qm[l]}) : $signed({1'b0, qm[l]});
      pv[l] = 64'(sp[l]);
      av[l] = (l == 0) ? 64'(mq.it.ax) : 64'(mq.it.ay);
      case (mq.it.op)
        OP_ORT:    val_next[l] = av[l] - pv[l];
        OP_MBY:    val_next[l] = (pv[l] <<< 1) - av[l];
        OP_MALONG: val_next[l] = av[l] - (pv[l] <<< 1);
        default:   val_next[l] = pv[l];
      endcase
    end
  end
  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else vc <= vq;
    mc     <= mq;
    val[0] <= val_next[0];
    val[1] <= val_next[1];
  end

  // B2: final pick and clamp
  sat_t tx, ty, tl;
  logic [31:0] rx_next, ry_next, rs_next;
  logic [1:0]  st_next;
  always_comb begin
    tx = sat32(val[0]);
    ty = sat32(val[1]);
    tl = sat32($signed(64'(mc.it.len)));
    rx_next = '0;
    ry_next = '0;
    rs_next = '0;
    st_next = ST_OK;
    unique case (mc.it.op) inside
      OP_DIV, OP_NORM, OP_PROJ, OP_ORT, OP_MBY, OP_MALONG: begin
        if (mc.dz) begin
          st_next = ST_DZ;
        end else begin
          rx_next = tx.val;
          ry_next = ty.val;
          st_next = (tx.clamp | ty.clamp) ? ST_SAT : ST_OK;
        end
      end
      OP_LEN: begin
        rs_next = tl.val;
        st_next = tl.clamp ? ST_SAT : ST_OK;
      end
      default: begin
        rx_next = mc.it.sx;
        ry_next = mc.it.sy;
        rs_next = mc.it.ss;
        st_next = mc.it.sclamp ? ST_SAT : ST_OK;
      end
    endcase
  end
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= vc;
    r_x        <= rx_next;
    r_y        <= ry_next;
    scalar_out <= rs_next;
    status     <= st_next;
  end

endmodule
`default_nettype wire

// ----- src/vector2d_geometry_alu.sv -----
// Top level of the 2D fixed-point vector ALU.
//
//  channel  | handshake      | fields
//  ---------+----------------+-----------------------------------------
//  command  | start / busy   | opcode, a_x, a_y, b_x, b_y, factor
//  result   | done (strobe)  | r_x, r_y, scalar_out, status
//
// Fully pipelined: one transaction per clock, busy is always low.
// Stages from the start input to the done output:
// 5 front stages, 34 square-root stages, 44 divider stages, 3 back stages.
// The divider and square root, one bit per stage, set the depth.
// Synchronous reset clears the valid bits only; results are never held off.
`default_nettype none
module vector2d_geometry_alu import vga_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [3:0]         opcode,
  input  wire logic signed [31:0] a_x,
  input  wire logic signed [31:0] a_y,
  input  wire logic signed [31:0] b_x,
  input  wire logic signed [31:0] b_y,
  input  wire logic signed [31:0] factor,
  output logic                    done,
  output logic signed [31:0]      r_x,
  output logic signed [31:0]      r_y,
  output logic signed [31:0]      scalar_out,
  output logic [1:0]              status
);

  logic              f_vld, s_vld, d_vld;
  item_t             f_item, s_item;
  dv_t               d_meta;
  logic [1:0][63:0]  d_rem;
  logic [1:0][QB-1:0] d_quo;

  assign busy = 1'b0;

  vga_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (start),
    .opcode   (opcode),
    .a_x      (a_x),
    .a_y      (a_y),
    .b_x      (b_x),
    .b_y      (b_y),
    .factor   (factor),
    .out_vld  (f_vld),
    .out_item (f_item)
  );

  vga_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (f_vld),
    .in_item  (f_item),
    .out_vld  (s_vld),
    .out_item (s_item)
  );

  vga_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (s_vld),
    .in_item  (s_item),
    .out_vld  (d_vld),
    .out_meta (d_meta),
    .out_rem  (d_rem),
    .out_quo  (d_quo)
  );

  vga_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_vld     (d_vld),
    .in_meta    (d_meta),
    .in_rem     (d_rem),
    .in_quo     (d_quo),
    .done       (done),
    .r_x        (r_x),
    .r_y        (r_y),
    .scalar_out (scalar_out),
    .status     (status)
  );

endmodule
`default_nettype wire
